// ----- rtl/utu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder package
// Word types for both channels, the job descriptor passed from the front end
// to the byte serialiser, and the code point encoder.
// ----------------------------------------------------------------------------
package utu_pkg;

  // Input word: one UTF-16 code unit and the end-of-string marker
  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_last;
  } in_word_t;

  // Output word: one UTF-8 byte with its framing flags
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_word_t;

  // Code point width and the values the front end works with
  localparam int unsigned CpW = 21;
  localparam logic [CpW-1:0] ReplCp = 21'h00FFFD;
  // 0x10000 >> 10, added to the high surrogate bits to form a pair
  localparam logic [10:0] PairBase = 11'h040;
  localparam logic [5:0] HighTag = 6'b110110;
  localparam logic [5:0] LowTag = 6'b110111;

  // Largest byte run that one code unit can cause
  localparam int unsigned MaxBytes = 6;
  localparam int unsigned CntW = 3;
  localparam logic [CntW-1:0] ReplLen = 3'd3;

  // Encoded code point: up to four bytes, byte 0 sent first
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } enc_t;

  // One queued job: the whole byte run of one input word
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
    logic                     last;
  } job_t;

  // UTF-8 encoding of one code point
  function automatic enc_t utu_encode(logic [CpW-1:0] cp);
    enc_t r;
    r = '0;
    if (cp < 21'h000080) begin
      r.bytes[0] = cp[7:0];
      r.len      = 3'd1;
    end else if (cp < 21'h000800) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.len      = 3'd2;
    end else if (cp < 21'h010000) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.len      = 3'd3;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.len      = 3'd4;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/utu_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 front end
// Accepts code units, tracks a held high surrogate and turns each word into
// a job holding its complete byte run. Words that cause no bytes are
// absorbed here.
// ----------------------------------------------------------------------------
module utu_front import utu_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_word_t in_word_i,
  input  wire logic     q_full_i,
  output logic          q_push_o,
  output job_t          q_job_o
);

  logic       pend_q, pend_d;
  logic [9:0] pend_bits_q, pend_bits_d;

  logic           accept;
  logic           is_high, is_low;
  logic           pair, flush;
  logic           main_en;
  logic [CpW-1:0] main_cp;
  logic [CpW-1:0] pair_cp;
  enc_t           main_enc;
  enc_t           repl_enc;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the unit
  assign is_high = (in_word_i.code_unit[15:10] == HighTag);
  assign is_low  = (in_word_i.code_unit[15:10] == LowTag);
  assign pair    = pend_q && is_low;
  assign flush   = pend_q && !is_low;
  assign pair_cp = {(11'(pend_bits_q) + PairBase), in_word_i.code_unit[9:0]};

  // Pick the code point this unit itself stands for
  always_comb begin
    main_en = 1'b1;
    main_cp = ReplCp;
    if (pair) begin
      main_cp = pair_cp;
    end else if (is_high) begin
      main_en = in_word_i.unit_last;
    end else if (is_low) begin
      main_cp = ReplCp;
    end else begin
      main_cp = {5'd0, in_word_i.code_unit};
    end
  end

  assign main_enc = utu_encode(main_cp);
  assign repl_enc = utu_encode(ReplCp);

  // Build the byte run: an optional flushed U+FFFD, then the unit's own bytes
  always_comb begin
    q_job_o      = '0;
    q_job_o.last = in_word_i.unit_last;
    if (flush) begin
      for (int k = 0; k < 3; k++) begin
        q_job_o.bytes[k]     = repl_enc.bytes[k];
        q_job_o.bytes[k + 3] = main_enc.bytes[k];
      end
      q_job_o.cnt = main_en ? 3'(ReplLen + main_enc.len) : ReplLen;
    end else begin
      for (int k = 0; k < 4; k++) begin
        q_job_o.bytes[k] = main_enc.bytes[k];
      end
      q_job_o.cnt = main_en ? main_enc.len : 3'd0;
    end
  end

  assign q_push_o = accept && (q_job_o.cnt != 3'd0);

  // Held high surrogate
  always_comb begin
    pend_d      = pend_q;
    pend_bits_d = pend_bits_q;
    if (accept) begin
      pend_d      = is_high && !in_word_i.unit_last;
      pend_bits_d = pend_d ? in_word_i.code_unit[9:0] : 10'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      pend_bits_q <= 10'd0;
    end else begin
      pend_q      <= pend_d;
      pend_bits_q <= pend_bits_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/utu_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 job queue
// Small first-in first-out buffer between the front end and the serialiser.
// ----------------------------------------------------------------------------
module utu_queue import utu_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output logic      full_o,
  output logic      valid_o,
  output job_t      head_o,
  input  wire logic pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntQW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntQW-1:0] FullCnt = CntQW'(Depth);

  job_t mem_q [Depth];

  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Job storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/utu_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 byte serialiser
// Walks the head job one byte per cycle, while the output is not stalled,
// into the output register and retires the job with its last byte.
// ----------------------------------------------------------------------------
module utu_back import utu_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  input  wire job_t q_job_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_word_t out_word_o
);

  logic            out_valid_q, out_valid_d;
  out_word_t       out_word_q, out_word_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            load;
  logic            at_end;

  assign load   = q_valid_i && (!out_valid_q || out_ready_i);
  assign at_end = (idx_q == 3'(q_job_i.cnt - 3'd1));

  // Next byte and index
  always_comb begin
    out_word_d            = out_word_q;
    out_word_d.out_byte   = q_job_i.bytes[idx_q];
    out_word_d.run_last   = at_end;
    out_word_d.string_end = at_end && q_job_i.last;
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = at_end ? '0 : idx_q + 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign q_pop_o = load && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
`default_nettype wire

// ----- rtl/utf16_to_utf8_transcoder_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder
// Converts a stream of UTF-16 code units into UTF-8 bytes, one byte per
// output word, with unpaired surrogates replaced by U+FFFD.
// ----------------------------------------------------------------------------
// Each input word carries one code unit. The block sends one output byte per
// cycle while the output is not stalled. A character of the basic plane causes
// one to three bytes, a completed surrogate pair four and a lone low surrogate
// three. A held high surrogate left without its partner puts three more bytes
// (U+FFFD) in front of the unit's own bytes, up to six in all. A high surrogate
// held for its partner causes none. The output byte rate of the serialiser sets
// the sustained throughput. Input words are taken every cycle while the job
// queue (QueueDepth entries) has room. With the queue and serialiser idle, an
// accepted word is registered in the job queue and its first byte then in the
// output register. run_last marks the final byte of each word's run and
// string_end the final byte of the string.
module utf16_to_utf8_transcoder_core import utu_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_word_t in_word_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_word_t     out_word_o
);

  logic q_full;
  logic q_push;
  job_t q_job;
  logic q_valid;
  job_t q_head;
  logic q_pop;

  utu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (q_job)
  );

  utu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head),
    .pop_i   (q_pop)
  );

  utu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire

// ----- rtl/utu_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 port checker
// Watches the output channel of the transcoder and its byte framing.
// ----------------------------------------------------------------------------
module utu_checker import utu_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_i,
  input wire logic      out_ready_i,
  input wire out_word_t out_word_i
);

  // A stalled word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  // A stalled word keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_word_i))
    else $error("output word changed while stalled");

  // End of string only on the last byte of a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.string_end |-> out_word_i.run_last)
    else $error("string end outside run end");

  // A run never closes on a multi-byte lead byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.run_last |-> out_word_i.out_byte[7:6] != 2'b11)
    else $error("run ends inside a sequence");

  // No byte outside the UTF-8 lead range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_word_i.out_byte[7:3] != 5'b11111)
    else $error("illegal UTF-8 byte");

endmodule

bind utf16_to_utf8_transcoder_core utu_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_i  (out_word_o)
);
`default_nettype wire
